/* design/slewed_system_clock_macros.svh */
// ----------------------------------------------------------------------------
// Slewed system clock assertion macros
// Shared clocked assertion forms for the clock block checkers.
// ----------------------------------------------------------------------------
`ifndef SLEWED_SYSTEM_CLOCK_MACROS_SVH
`define SLEWED_SYSTEM_CLOCK_MACROS_SVH

// property checked on every rising edge, off while reset is low
`define SSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("slewed clock check failed");

// boolean condition that must never be seen
`define SSC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("slewed clock forbidden condition seen");

`endif

/* design/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// Slewed system clock package
// Request and response types, register indexes and divider constants.
// ----------------------------------------------------------------------------
package ssc_pkg;

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_SET  = 2'd1,
    REQ_READ = 2'd2
  } req_type_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [15:0]        tick_usec;
    logic signed [63:0] target_time;
    logic               use_gmt;
  } req_t;

  typedef struct packed {
    logic [62:0]        uptime_now;
    logic signed [63:0] local_now;
    logic signed [63:0] correction_left;
    logic [6:0]         ms_events;
    logic               second_event;
  } rsp_t;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 37;
  localparam logic [CfgIdxW-1:0] CFG_TZ_OFFSET  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_JUMP_LIMIT = 1'b1;

  localparam logic [36:0] TZ_OFFSET_RST  = 37'd0;
  localparam logic [31:0] JUMP_LIMIT_RST = 32'd900000000;

  // millisecond / second dividers
  localparam int unsigned UsecPerMs   = 1000;
  localparam int unsigned MsPerSec    = 1000;
  // floor(x / 1000) = (x * MsRecip) >> MsShift, exact for x < 2^18
  localparam int unsigned MsRecip     = 134218;
  localparam int unsigned MsShift     = 27;
  localparam logic [6:0]  MS_EVENTS_MAX = 7'd66;

endpackage

/* design/slewed_system_clock.sv */
// ----------------------------------------------------------------------------
// Slewed system clock
// Microsecond uptime counter with a slewed real-time offset and ms/s events.
// ----------------------------------------------------------------------------
// One request per cycle, sustained, while out_ready_i is not held low. A
// request is captured in the input register, does its whole update (tick
// slew, set-time compare, read) in the one combinational pass to the result
// register, and its response shows on out_valid_o once it is registered there.
// The clock state updates as each request moves into the result register, so
// back-to-back requests see each other's effect. The result register holds a
// stalled response while the input register can take one more request.
// Configuration: index 0 timezone offset (37 bit signed), index 1 jump limit.
module slewed_system_clock (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ssc_pkg::req_t                   in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ssc_pkg::rsp_t                   out_rsp_o,
  input  logic                            cfg_we_i,
  input  logic [ssc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ssc_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  // configuration
  logic [36:0] tz_q;
  logic [31:0] jump_q;

  // pipeline
  ssc_pkg::req_t req_q;
  logic          in_valid_q;
  ssc_pkg::rsp_t rsp_q, rsp_d;
  logic          out_valid_q;
  logic          advance;

  // clock state
  logic [62:0] uptime_q, uptime_d;
  logic [63:0] offset_q, offset_d;
  logic [63:0] pend_q, pend_d;
  logic [9:0]  acc_q, acc_d;
  logic [9:0]  ms_q, ms_d;

  // shared terms
  logic [63:0] tz_ext;
  logic [63:0] base;
  logic [15:0] tick;
  logic        tick_nz;

  // tick path
  logic        pc_neg, pc_pos, pc_gt_tick, mag_ge_tick;
  logic [63:0] pc_mag;
  logic [15:0] fwd_step, back_step;
  logic [62:0] uptime_tick;
  logic [63:0] offset_tick, pend_tick;
  logic [16:0] acc_sum;
  logic [34:0] recip_prod;
  logic [6:0]  ms_n;
  logic [16:0] acc_rem;
  logic [10:0] ms_sum;
  logic        sec_hit;

  // set path
  logic [63:0] now_set, diff, diff_mag;
  logic        do_step;

  assign advance     = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o  = ~in_valid_q | advance;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  assign tz_ext  = {{27{tz_q[36]}}, tz_q};
  assign base    = {1'b0, uptime_q} + offset_q;
  assign tick    = req_q.tick_usec;
  assign tick_nz = (tick != 16'd0);

  // slew step for the pending correction
  assign pc_neg      = pend_q[63];
  assign pc_pos      = ~pend_q[63] & (pend_q != 64'd0);
  assign pc_gt_tick  = pend_q > {48'd0, tick};
  assign fwd_step    = pc_gt_tick ? tick : pend_q[15:0];
  assign pc_mag      = 64'd0 - pend_q;
  assign mag_ge_tick = pc_mag >= {48'd0, tick};
  assign back_step   = mag_ge_tick ? (tick - 16'd1) : pc_mag[15:0];

  always_comb begin
    offset_tick = offset_q;
    pend_tick   = pend_q;
    if (pc_pos) begin
      offset_tick = offset_q + {48'd0, fwd_step};
      pend_tick   = pend_q - {48'd0, fwd_step};
    end else if (pc_neg) begin
      offset_tick = offset_q - {48'd0, back_step};
      pend_tick   = pend_q + {48'd0, back_step};
    end
  end

  assign uptime_tick = uptime_q + {47'd0, tick};

  // millisecond divider: reciprocal multiply by 1/1000
  assign acc_sum    = {7'd0, acc_q} + {1'b0, tick};
  assign recip_prod = 35'(acc_sum) * 35'(ssc_pkg::MsRecip);
  assign ms_n       = recip_prod[ssc_pkg::MsShift+6:ssc_pkg::MsShift];
  assign acc_rem    = acc_sum - 17'(ms_n * 17'(ssc_pkg::UsecPerMs));
  assign ms_sum     = {1'b0, ms_q} + {4'd0, ms_n};
  assign sec_hit    = ms_sum >= 11'(ssc_pkg::MsPerSec);

  // set time
  assign now_set  = req_q.use_gmt ? base : (base + tz_ext);
  assign diff     = req_q.target_time - now_set;
  assign diff_mag = diff[63] ? (64'd0 - diff) : diff;
  assign do_step  = (diff != 64'd0) & (diff_mag > {32'd0, jump_q});

  always_comb begin
    uptime_d = uptime_q;
    offset_d = offset_q;
    pend_d   = pend_q;
    acc_d    = acc_q;
    ms_d     = ms_q;
    rsp_d.uptime_now      = uptime_q;
    rsp_d.local_now       = base + tz_ext;
    rsp_d.correction_left = pend_q;
    rsp_d.ms_events       = 7'd0;
    rsp_d.second_event    = 1'b0;
    unique case (req_q.req_type)
      ssc_pkg::REQ_TICK: begin
        if (tick_nz) begin
          uptime_d = uptime_tick;
          offset_d = offset_tick;
          pend_d   = pend_tick;
          acc_d    = acc_rem[9:0];
          ms_d     = sec_hit ? 10'(ms_sum - 11'(ssc_pkg::MsPerSec)) : ms_sum[9:0];
          rsp_d.uptime_now      = uptime_tick;
          rsp_d.local_now       = {1'b0, uptime_tick} + offset_tick + tz_ext;
          rsp_d.correction_left = pend_tick;
          rsp_d.ms_events       = ms_n;
          rsp_d.second_event    = sec_hit;
        end
      end
      ssc_pkg::REQ_SET: begin
        if (do_step) begin
          offset_d = offset_q + diff;
          pend_d   = 64'd0;
          // stepped local time lands on the target, shifted by tz for gmt
          rsp_d.local_now = req_q.use_gmt ? (req_q.target_time + tz_ext)
                                          : req_q.target_time;
          rsp_d.correction_left = 64'd0;
        end else begin
          pend_d = diff;
          rsp_d.correction_left = diff;
        end
      end
      default: begin
        // read, and the unused code behaves as a read
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tz_q        <= ssc_pkg::TZ_OFFSET_RST;
      jump_q      <= ssc_pkg::JUMP_LIMIT_RST;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      uptime_q    <= '0;
      offset_q    <= '0;
      pend_q      <= '0;
      acc_q       <= '0;
      ms_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ssc_pkg::CFG_TZ_OFFSET:  tz_q   <= cfg_wdata_i[36:0];
          ssc_pkg::CFG_JUMP_LIMIT: jump_q <= cfg_wdata_i[31:0];
        endcase
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        uptime_q    <= uptime_d;
        offset_q    <= offset_d;
        pend_q      <= pend_d;
        acc_q       <= acc_d;
        ms_q        <= ms_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

/* design/ssc_checker.sv */
// ----------------------------------------------------------------------------
// Slewed system clock checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "slewed_system_clock_macros.svh"

module ssc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ssc_pkg::rsp_t out_rsp_o
);

  `SSC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)
  `SSC_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_rsp_o))
  // an empty result register never blocks a new request
  `SSC_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o)
  // a second boundary only comes with at least one ms boundary
  `SSC_ASSERT(a_sec_has_ms, out_valid_o && out_rsp_o.second_event |-> out_rsp_o.ms_events != 7'd0)
  `SSC_ASSERT_NEVER(a_ms_bound, out_valid_o && (out_rsp_o.ms_events > ssc_pkg::MS_EVENTS_MAX))

endmodule

bind slewed_system_clock ssc_checker u_ssc_checker (.*);

/* bench/tb_slewed_system_clock.sv */
// ----------------------------------------------------------------------------
// Slewed system clock testbench
// Sends tick, set-time and read requests and checks every response against
// an in-bench clock predictor. Covers the divider edges, positive and negative
// slew, stepping at the jump limit, register extremes, random idling on both
// sides, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_slewed_system_clock;
  import ssc_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam req_type_e REQ_UNUSED = req_type_e'(2'd3);
  localparam logic [36:0] TZ_EAST = 37'd50400000000;
  localparam logic [36:0] TZ_WEST = -37'd50400000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_rsp_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  slewed_system_clock uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predicted clock state and register copies
  logic [62:0] up_us = '0;
  logic [63:0] rt_offset = '0;
  logic [63:0] slew_pending = '0;
  int unsigned usec_acc = 0;
  int unsigned ms_count = 0;
  logic [36:0] tz_reg = TZ_OFFSET_RST;
  logic [31:0] jump_reg = JUMP_LIMIT_RST;

  rsp_t expected_rsp[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned hold_off_request = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] tz_wide();
    return {{27{tz_reg[36]}}, tz_reg};
  endfunction

  function automatic logic [63:0] wall_clock_us(logic gmt);
    return {1'b0, up_us} + rt_offset + (gmt ? 64'd0 : tz_wide());
  endfunction

  // applies one request to the predicted clock and returns its response
  function automatic rsp_t advance_clock(req_t r);
    logic [63:0] pc, mag, shift, back, diff;
    logic [15:0] t;
    int unsigned n;
    rsp_t o;
    o = '0;
    t = r.tick_usec;
    case (r.req_type)
      REQ_TICK: begin
        if (t != 16'd0) begin
          pc = slew_pending;
          if (pc != 64'd0 && !pc[63]) begin
            shift = (pc > 64'(t)) ? 64'(t) : pc;
            rt_offset = rt_offset + shift;
            slew_pending = pc - shift;
          end else if (pc[63]) begin
            // a negative slew never takes a whole tick back
            mag = -pc;
            back = (mag >= 64'(t)) ? 64'(t) - 64'd1 : mag;
            rt_offset = rt_offset - back;
            slew_pending = pc + back;
          end
          up_us = up_us + 63'(t);
          usec_acc = usec_acc + t;
          n = usec_acc / UsecPerMs;
          usec_acc = usec_acc - n * UsecPerMs;
          o.ms_events = 7'(n);
          ms_count = ms_count + n;
          if (ms_count >= MsPerSec) begin
            ms_count = ms_count - MsPerSec;
            o.second_event = 1'b1;
          end
        end
      end
      REQ_SET: begin
        diff = r.target_time - wall_clock_us(r.use_gmt);
        mag = diff[63] ? -diff : diff;
        if (diff != 64'd0 && mag > {32'd0, jump_reg}) begin
          rt_offset = rt_offset + diff;
          diff = 64'd0;
        end
        slew_pending = diff;
      end
      default: begin
      end
    endcase
    o.uptime_now = up_us;
    o.local_now = wall_clock_us(1'b0);
    o.correction_left = slew_pending;
    return o;
  endfunction

  task automatic send_request(req_t r);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    expected_rsp.push_back(advance_clock(r));
  endtask

  function automatic req_t make_request(req_type_e kind, logic [15:0] tick,
                                        logic [63:0] target, logic gmt);
    req_t r;
    r.req_type = kind;
    r.tick_usec = tick;
    r.target_time = target;
    r.use_gmt = gmt;
    return r;
  endfunction

  task automatic send_tick(logic [15:0] tick);
    send_request(make_request(REQ_TICK, tick, {$urandom, $urandom}, 1'($urandom)));
  endtask

  task automatic send_set(logic [63:0] target, logic gmt);
    send_request(make_request(REQ_SET, 16'($urandom), target, gmt));
  endtask

  task automatic send_read();
    send_request(make_request(REQ_READ, 16'($urandom), {$urandom, $urandom}, 1'($urandom)));
  endtask

  // mostly sets close to the current time so slews actually run
  function automatic req_t random_request();
    req_t r;
    int unsigned pick;
    logic [31:0] w;
    logic [63:0] delta;
    pick = $urandom_range(0, 99);
    r.use_gmt = 1'($urandom);
    r.target_time = {$urandom, $urandom};
    if ($urandom_range(0, 40) == 0) r.tick_usec = 16'd0;
    else if ($urandom_range(0, 1) == 0) r.tick_usec = 16'($urandom);
    else r.tick_usec = 16'($urandom_range(1, 2500));
    if (pick < 60) begin
      r.req_type = REQ_TICK;
    end else if (pick < 82) begin
      r.req_type = REQ_SET;
      w = $urandom;
      delta = 64'd0;
      case ($urandom_range(0, 3))
        0: delta = 64'($urandom_range(0, 20000));
        1: delta = {32'd0, jump_reg} + 64'($urandom_range(0, 4)) - 64'd2;
        2: delta = {{32{w[31]}}, w};
        default: delta = 64'd0;
      endcase
      if ($urandom_range(0, 1) == 0) delta = -delta;
      if (delta != 64'd0 || $urandom_range(0, 3) == 0) begin
        r.target_time = wall_clock_us(r.use_gmt) + delta;
      end
    end else if (pick < 95) begin
      r.req_type = REQ_READ;
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  task automatic run_random_items(int unsigned count);
    repeat (count) send_request(random_request());
  endtask

  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [36:0] tz, logic [31:0] jl);
    wait_for_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_TZ_OFFSET;
    cfg_wdata_i <= tz;
    @(posedge clk_i);
    cfg_idx_i <= CFG_JUMP_LIMIT;
    cfg_wdata_i <= {5'd0, jl};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tz_reg = tz;
    jump_reg = jl;
  endtask

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s mismatch, expected %h got %h", $realtime, what, want, got);
    end
  endtask

  task automatic check_response(rsp_t got);
    rsp_t want;
    if (expected_rsp.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: response with no request pending", $realtime);
    end else begin
      want = expected_rsp.pop_front();
      if (got.uptime_now !== want.uptime_now)
        report_mismatch("uptime_now", 64'(want.uptime_now), 64'(got.uptime_now));
      if (got.local_now !== want.local_now)
        report_mismatch("local_now", want.local_now, got.local_now);
      if (got.correction_left !== want.correction_left)
        report_mismatch("correction_left", want.correction_left, got.correction_left);
      if (got.ms_events !== want.ms_events)
        report_mismatch("ms_events", 64'(want.ms_events), 64'(got.ms_events));
      if (got.second_event !== want.second_event)
        report_mismatch("second_event", 64'(want.second_event), 64'(got.second_event));
    end
  endtask

  // receiver: checks responses and drives ready with stalls and hold-offs
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) check_response(out_rsp_o);
    if (hold_off_request != 0) begin
      stall_left = hold_off_request;
      hold_off_request = 0;
    end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19);
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // runs at reset settings: divider edges, slew directions, jump limit edges
  task automatic test_directed_cases();
    logic [63:0] jl;
    jl = {32'd0, jump_reg};
    send_read();
    send_request(make_request(REQ_UNUSED, 16'hFFFF, '1, 1'b1));
    send_tick(16'd0);
    send_tick(16'd1);
    send_tick(16'd999);
    send_tick(16'hFFFF);
    send_set(wall_clock_us(1'b1) + 64'd5000, 1'b1);
    send_tick(16'd3000);
    send_tick(16'd3000);
    send_tick(16'd1);
    send_set(wall_clock_us(1'b1) - 64'd5000, 1'b1);
    send_tick(16'd1000);
    send_tick(16'd10000);
    send_set(wall_clock_us(1'b1) - 64'd1000, 1'b1);
    send_tick(16'd1000);
    // one microsecond left behind cannot move on a 1 us tick
    send_tick(16'd1);
    send_tick(16'd2);
    send_set(wall_clock_us(1'b1), 1'b1);
    send_set(wall_clock_us(1'b1) + jl, 1'b1);
    send_set(wall_clock_us(1'b1) - jl, 1'b1);
    send_set(wall_clock_us(1'b1) + jl + 64'd1, 1'b1);
    send_set(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_set(64'h8000_0000_0000_0000, 1'b1);
    send_read();
  endtask

  task automatic test_register_extremes();
    apply_settings(TZ_EAST, 32'd0);
    run_random_items(25);
    apply_settings(TZ_WEST, 32'd3600000000);
    run_random_items(25);
    apply_settings(37'h0F_FFFF_FFFF, 32'hFFFF_FFFF);
    run_random_items(25);
    apply_settings(37'h10_0000_0000, 32'd1);
    run_random_items(25);
  endtask

  task automatic test_random_traffic();
    logic [31:0] jl;
    for (int phase = 0; phase < 4; phase++) begin
      jl = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 100000)) : $urandom;
      apply_settings(37'({$urandom, $urandom}), jl);
      // one phase runs without any idling on either side
      tx_idle_en = (phase != 2);
      rx_idle_en = (phase != 2);
      run_random_items(65);
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_output_backpressure();
    tx_idle_en = 1'b0;
    hold_off_request = 80;
    run_random_items(20);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_full_rate();
    apply_settings(37'({$urandom, $urandom}), 32'($urandom_range(0, 50000)));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_random_items(60);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_register_extremes();
    test_random_traffic();
    test_output_backpressure();
    test_full_rate();
    wait_for_idle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
